// ----- src/pes_pkg.sv -----
// ============================================================================
// pes_pkg - shared types and codes for the periodic event scheduler
// Job record layout, request and status codes, and the cell operation code.
// ============================================================================
package pes_pkg;

   // request function codes
   localparam logic FUNC_REGISTER = 1'b0;
   localparam logic FUNC_FIRE     = 1'b1;

   // response status codes
   localparam logic [1:0] STATUS_REGISTERED = 2'd0;
   localparam logic [1:0] STATUS_FULL       = 2'd1;
   localparam logic [1:0] STATUS_FIRED      = 2'd2;
   localparam logic [1:0] STATUS_EMPTY      = 2'd3;

   // one job as held in a cell; due/id come first so the pair sorts directly
   typedef struct packed {
      logic [31:0] due;
      logic [15:0] id;
      logic [15:0] period;
   } job_type;

   // operation broadcast along the row of cells
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_POP
   } cell_op_type;

endpackage

// ----- src/pes_if.sv -----
// ============================================================================
// pes_req_if / pes_rsp_if - valid/ready channels of the scheduler
// Request carries a register or fire command; response carries the outcome.
// ============================================================================
interface pes_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [15:0] job_id;
   logic [15:0] job_period;

   modport source (output valid, output func, output job_id, output job_period,
                   input ready);
   modport sink   (input valid, input func, input job_id, input job_period,
                   output ready);
endinterface

interface pes_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] fired_id;
   logic [31:0] fired_time;

   modport source (output valid, output status, output fired_id, output fired_time,
                   input ready);
   modport sink   (input valid, input status, input fired_id, input fired_time,
                   output ready);
endinterface

// ----- src/pes_cell.sv -----
// ============================================================================
// pes_cell - one slot of the sorted job row
// Holds one job; on insert it keeps, takes the new job or takes its left
// neighbour; on pop it takes its right neighbour.
// ============================================================================
module pes_cell #(
   parameter int SLOT_W = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pes_pkg::cell_op_type op,
   input  pes_pkg::job_type     new_job,
   input  logic [SLOT_W-1:0]    new_slot,
   input  logic                 prev_valid,
   input  pes_pkg::job_type     prev_job,
   input  logic [SLOT_W-1:0]    prev_slot,
   input  logic                 prev_lt,
   input  logic                 next_valid,
   input  pes_pkg::job_type     next_job,
   input  logic [SLOT_W-1:0]    next_slot,
   output logic                 valid,
   output pes_pkg::job_type     job,
   output logic [SLOT_W-1:0]    slot,
   output logic                 lt
);

   logic                valid_ff, valid_in;
   pes_pkg::job_type    job_ff, job_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;

   // new job sorts ahead of this one; slot breaks equal due/id in arrival order
   assign lt = !valid_ff ||
               ({new_job.due, new_job.id, new_slot} < {job_ff.due, job_ff.id, slot_ff});

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      slot_in  = slot_ff;
      case (op)
         pes_pkg::OP_INSERT: begin
            if (lt) begin
               if (prev_lt) begin
                  valid_in = prev_valid;
                  job_in   = prev_job;
                  slot_in  = prev_slot;
               end else begin
                  valid_in = 1'b1;
                  job_in   = new_job;
                  slot_in  = new_slot;
               end
            end
         end
         pes_pkg::OP_POP: begin
            valid_in = next_valid;
            job_in   = next_job;
            slot_in  = next_slot;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff  <= job_in;
      slot_ff <= slot_in;
   end

   assign valid = valid_ff;
   assign job   = job_ff;
   assign slot  = slot_ff;

endmodule

// ----- src/periodic_event_scheduler.sv -----
// ============================================================================
// periodic_event_scheduler - periodic job table kept as a sorted cell row
// Registers periodic jobs and fires the earliest due one on request.
// ============================================================================
// Usage:
//  req_ch  : func 0 registers job_id with job_period (first due = period);
//            func 1 fires the job with the smallest due time, smaller id first.
//  rsp_ch  : one transfer per request: status, and for a fire the job's id and
//            due time before it advances by its period (saturating at all ones).
//  Jobs live in a row of MAX_JOBS cells kept sorted by (due, id, arrival), so
//  the head cell is always the next job to fire.
//  The response is registered and valid the cycle after the request transfer.
//  A register is one insert pass over the row; a fire is a pop of the head,
//  then a re-insert of the advanced job, during which no request is taken.
//  A new request is taken only while the row is idle and the response
//  register is empty or being drained in the same cycle, so a stalled
//  receiver holds off further requests without losing anything.
//  Reset (synchronous, active high) empties the row and clears the job count
//  at once; no clearing pass is needed.
// ============================================================================
module periodic_event_scheduler #(
   parameter int MAX_JOBS = 64
) (
   input  logic       clock,
   input  logic       reset,
   pes_req_if.sink    req_ch,
   pes_rsp_if.source  rsp_ch
);

   localparam int SLOT_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W  = $clog2(MAX_JOBS + 1);

   // sequencer codes
   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_REINS = 1'b1;

   logic state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // job waiting to go back into the row after a fire
   pes_pkg::job_type  reins_job_ff, reins_job_in;
   logic [SLOT_W-1:0] reins_slot_ff, reins_slot_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        status_ff, status_in;
   logic [15:0]       fired_id_ff, fired_id_in;
   logic [31:0]       fired_time_ff, fired_time_in;

   // row wiring
   logic              cell_valid [MAX_JOBS];
   pes_pkg::job_type  cell_job   [MAX_JOBS];
   logic [SLOT_W-1:0] cell_slot  [MAX_JOBS];
   logic              cell_lt    [MAX_JOBS];

   pes_pkg::cell_op_type op;
   pes_pkg::job_type     new_job;
   logic [SLOT_W-1:0]    new_slot;

   logic accept;
   logic full;
   logic [32:0] due_sum;

   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (count_ff == CNT_W'(MAX_JOBS));

   // slots are never freed, so the count doubles as the arrival stamp
   assign due_sum = {1'b0, cell_job[0].due} + {17'd0, cell_job[0].period};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      reins_job_in  = reins_job_ff;
      reins_slot_in = reins_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      status_in     = status_ff;
      fired_id_in   = fired_id_ff;
      fired_time_in = fired_time_ff;
      op            = pes_pkg::OP_HOLD;
      new_job.due    = {16'd0, req_ch.job_period};
      new_job.id     = req_ch.job_id;
      new_job.period = req_ch.job_period;
      new_slot       = count_ff[SLOT_W-1:0];

      if (state_ff == ST_REINS) begin
         // second half of a fire: put the advanced job back in order
         op       = pes_pkg::OP_INSERT;
         new_job  = reins_job_ff;
         new_slot = reins_slot_ff;
         state_in = ST_IDLE;
      end else if (accept) begin
         rsp_valid_in  = 1'b1;
         fired_id_in   = 16'd0;
         fired_time_in = 32'd0;
         if (req_ch.func == pes_pkg::FUNC_REGISTER) begin
            if (full) begin
               status_in = pes_pkg::STATUS_FULL;
            end else begin
               op        = pes_pkg::OP_INSERT;
               count_in  = count_ff + CNT_W'(1);
               status_in = pes_pkg::STATUS_REGISTERED;
            end
         end else if (!cell_valid[0]) begin
            status_in = pes_pkg::STATUS_EMPTY;
         end else begin
            op                 = pes_pkg::OP_POP;
            status_in          = pes_pkg::STATUS_FIRED;
            fired_id_in        = cell_job[0].id;
            fired_time_in      = cell_job[0].due;
            reins_job_in       = cell_job[0];
            reins_job_in.due   = due_sum[32] ? 32'hFFFF_FFFF : due_sum[31:0];
            reins_slot_in      = cell_slot[0];
            state_in           = ST_REINS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      reins_job_ff  <= reins_job_in;
      reins_slot_ff <= reins_slot_in;
      status_ff     <= status_in;
      fired_id_ff   <= fired_id_in;
      fired_time_ff <= fired_time_in;
   end

   // sorted row: cell 0 is the head, each cell sees both neighbours
   for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
      logic              p_valid, n_valid, p_lt;
      pes_pkg::job_type  p_job, n_job;
      logic [SLOT_W-1:0] p_slot, n_slot;

      if (i == 0) begin : g_head
         assign p_valid = 1'b0;
         assign p_job   = '0;
         assign p_slot  = '0;
         assign p_lt    = 1'b0;
      end else begin : g_mid
         assign p_valid = cell_valid[i-1];
         assign p_job   = cell_job[i-1];
         assign p_slot  = cell_slot[i-1];
         assign p_lt    = cell_lt[i-1];
      end

      if (i == MAX_JOBS - 1) begin : g_tail
         assign n_valid = 1'b0;
         assign n_job   = '0;
         assign n_slot  = '0;
      end else begin : g_body
         assign n_valid = cell_valid[i+1];
         assign n_job   = cell_job[i+1];
         assign n_slot  = cell_slot[i+1];
      end

      pes_cell #(
         .SLOT_W (SLOT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .new_job    (new_job),
         .new_slot   (new_slot),
         .prev_valid (p_valid),
         .prev_job   (p_job),
         .prev_slot  (p_slot),
         .prev_lt    (p_lt),
         .next_valid (n_valid),
         .next_job   (n_job),
         .next_slot  (n_slot),
         .valid      (cell_valid[i]),
         .job        (cell_job[i]),
         .slot       (cell_slot[i]),
         .lt         (cell_lt[i])
      );
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.fired_id   = fired_id_ff;
   assign rsp_ch.fired_time = fired_time_ff;

endmodule

// ----- tb/periodic_event_scheduler_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// periodic_event_scheduler_test - self-checking bench for the job scheduler
// Drives register and fire requests through the request channel and checks
// every response transfer against a behavioural copy of the job table.
// The bench runs directed cases first: fire on an empty table, ties and field
// extremes. Random traffic follows under four idling mixes, then a long
// receiver hold-off, a zero period and a full table.
// ============================================================================
module periodic_event_scheduler_test;

   localparam int TABLE_DEPTH      = 64;
   localparam int LONG_HOLD_CYCLES = 400;
   // cycles without any transfer before the run is declared hung
   localparam int STALL_LIMIT      = 4000;
   // response is registered in the cycle after the request, so a short quiet tail is plenty
   localparam int END_QUIET_CYCLES = 20;
   localparam int RANDOM_ITEMS     = 220;

   // one response as the block should produce it
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] fired_id;
      logic [31:0] fired_time;
   } outcome_type;

   logic clock = 1'b0;
   logic reset;

   pes_req_if req_ch ();
   pes_rsp_if rsp_ch ();

   periodic_event_scheduler #(
      .MAX_JOBS (TABLE_DEPTH)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // behavioural job table: one record per slot, lowest free slot is taken
   pes_pkg::job_type job_slot [TABLE_DEPTH];
   bit          slot_used [TABLE_DEPTH];
   int          jobs_held;

   outcome_type pending_outcomes [$];
   int          mismatch_count;
   int          idle_cycles;

   // idling mix, percent of cycles; set by the running test
   int          sender_idle_pct;
   int          receiver_stall_pct;

   // long hold-offs asked for by a test, and those the receiver has carried out
   int          long_holds_asked;
   int          long_holds_done;
   int          hold_cycles_left;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Job table update for one accepted request; returns the response it causes.
   // Fire picks the smallest (due, id); on a full tie the lower slot wins, which
   // the strict compare gives for free since slots are scanned upwards.
   // -------------------------------------------------------------------------
   function automatic outcome_type next_outcome(input logic        func,
                                                input logic [15:0] req_id,
                                                input logic [15:0] req_period);
      outcome_type res;
      int          pick;
      logic [32:0] advanced;
      res  = '{status: pes_pkg::STATUS_FULL, fired_id: 16'h0000,
               fired_time: 32'h0000_0000};
      pick = -1;
      if (func == pes_pkg::FUNC_REGISTER) begin
         for (int s = 0; s < TABLE_DEPTH; s++) begin
            if (pick < 0 && !slot_used[s])
               pick = s;
         end
         if (pick >= 0) begin
            // first due time is the period itself
            job_slot[pick]  = '{due: {16'h0000, req_period}, id: req_id, period: req_period};
            slot_used[pick] = 1'b1;
            jobs_held++;
            res.status = pes_pkg::STATUS_REGISTERED;
         end
      end else begin
         for (int s = 0; s < TABLE_DEPTH; s++) begin
            if (slot_used[s]) begin
               if (pick < 0)
                  pick = s;
               else if ({job_slot[s].due, job_slot[s].id} <
                        {job_slot[pick].due, job_slot[pick].id})
                  pick = s;
            end
         end
         if (pick < 0) begin
            res.status = pes_pkg::STATUS_EMPTY;
         end else begin
            res.status     = pes_pkg::STATUS_FIRED;
            res.fired_id   = job_slot[pick].id;
            res.fired_time = job_slot[pick].due;
            // advance by the job's own period, sticking at all ones on overflow
            advanced = {1'b0, job_slot[pick].due} + {17'h0, job_slot[pick].period};
            job_slot[pick].due = advanced[32] ? 32'hFFFF_FFFF : advanced[31:0];
         end
      end
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Offer one request and wait for its transfer. Valid stays high afterwards
   // so back-to-back requests follow without a gap; it only drops for an idle
   // gap or at the end of a test.
   // -------------------------------------------------------------------------
   task automatic send_request(input logic func, input logic [15:0] req_id,
                               input logic [15:0] req_period);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.func       <= func;
      req_ch.job_id     <= req_id;
      req_ch.job_period <= req_period;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      pending_outcomes.push_back(next_outcome(func, req_id, req_period));
   endtask

   // drop valid and let every outstanding response come back
   task automatic wait_for_outcomes;
      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // fire fields are don't-care, so they carry random bits
   task automatic send_fire;
      send_request(pes_pkg::FUNC_FIRE, 16'($urandom), 16'($urandom));
   endtask

   // -------------------------------------------------------------------------
   // Random request: ids drawn mostly from a handful of values so that equal
   // ids and equal due times turn up often; periods often short for the same
   // reason. One slot is kept free for the zero-period case near the end.
   // -------------------------------------------------------------------------
   task automatic send_random_request;
      logic        do_fire;
      logic [15:0] req_id;
      logic [15:0] req_period;
      do_fire = ($urandom_range(99) < 55) || (jobs_held >= TABLE_DEPTH - 1);
      case ($urandom_range(3))
         0, 1:    req_id = 16'($urandom_range(7));
         2:       req_id = 16'($urandom);
         default: req_id = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
      case ($urandom_range(4))
         0, 1:    req_period = 16'($urandom_range(16, 1));
         2, 3:    req_period = 16'($urandom_range(65535, 1));
         default: req_period = $urandom_range(1) ? 16'hFFFF : 16'h0001;
      endcase
      if (do_fire)
         send_fire();
      else
         send_request(pes_pkg::FUNC_REGISTER, req_id, req_period);
   endtask

   // ---------------------------------------------------------------- tests ---

   // nothing registered yet: fire must report an empty table
   task automatic test_fire_on_empty_table;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_fire();
      send_fire();
      wait_for_outcomes();
   endtask

   // equal ids with different periods, equal due times with different ids,
   // and the field extremes
   task automatic test_ties_and_extremes;
      sender_idle_pct    = 20;
      receiver_stall_pct = 20;
      send_request(pes_pkg::FUNC_REGISTER, 16'd5, 16'd3);
      send_request(pes_pkg::FUNC_REGISTER, 16'd4, 16'd6);
      send_request(pes_pkg::FUNC_REGISTER, 16'd5, 16'd6);
      send_request(pes_pkg::FUNC_REGISTER, 16'h0000, 16'hFFFF);
      send_request(pes_pkg::FUNC_REGISTER, 16'h8000, 16'h0001);
      for (int n = 0; n < 12; n++)
         send_fire();
      wait_for_outcomes();
   endtask

   task automatic test_random_traffic(input int items, input int idle_pct,
                                      input int stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < items; n++)
         send_random_request();
      wait_for_outcomes();
   endtask

   // receiver holds off for a long stretch while requests keep coming, so the
   // response register fills and the block must stall its request side
   task automatic test_receiver_backpressure;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      long_holds_asked++;
      for (int n = 0; n < 16; n++)
         send_random_request();
      wait_for_outcomes();
   endtask

   // zero period: due time zero that never moves, so it wins every fire
   task automatic test_zero_period;
      sender_idle_pct    = 0;
      receiver_stall_pct = 30;
      send_request(pes_pkg::FUNC_REGISTER, 16'd9, 16'h0000);
      for (int n = 0; n < 4; n++)
         send_fire();
      wait_for_outcomes();
   endtask

   // fill every slot, then registers must be refused and change nothing
   task automatic test_table_full;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      while (jobs_held < TABLE_DEPTH)
         send_request(pes_pkg::FUNC_REGISTER, 16'($urandom),
                      16'($urandom_range(65535, 1)));
      send_request(pes_pkg::FUNC_REGISTER, 16'h0000, 16'hFFFF);
      send_request(pes_pkg::FUNC_REGISTER, 16'hFFFF, 16'h0001);
      send_fire();
      send_request(pes_pkg::FUNC_REGISTER, 16'h1234, 16'h0000);
      send_fire();
      wait_for_outcomes();
   endtask

   // ------------------------------------------------------------- receiver ---
   // Outside reset and a hold-off, ready is redrawn every cycle from the stall mix;
   // a long hold-off asked for by a test is counted down here.
   initial begin : drive_rsp_ready
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles_left == 0 && long_holds_done < long_holds_asked) begin
            long_holds_done++;
            hold_cycles_left = LONG_HOLD_CYCLES;
         end
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_cycles_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // -------------------------------------------------------------- checker ---
   // Each response transfer is matched against the oldest outstanding outcome.
   always @(posedge clock) begin : check_outcomes
      outcome_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response transfer with no request outstanding: status %0d",
                   rsp_ch.status);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
               mismatch_count++;
            end
            if (rsp_ch.fired_id !== want.fired_id) begin
               $error("fired_id: expected 0x%04h, actual 0x%04h",
                      want.fired_id, rsp_ch.fired_id);
               mismatch_count++;
            end
            if (rsp_ch.fired_time !== want.fired_time) begin
               $error("fired_time: expected 0x%08h, actual 0x%08h",
                      want.fired_time, rsp_ch.fired_time);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------- watchdog ---
   // Counts cycles with no transfer on either channel; a hung block ends here.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("periodic_event_scheduler_test NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------ test flow ---
   initial begin : run_tests
      mismatch_count     = 0;
      jobs_held          = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      long_holds_asked   = 0;
      long_holds_done    = 0;
      hold_cycles_left   = 0;
      idle_cycles        = 0;
      for (int s = 0; s < TABLE_DEPTH; s++)
         slot_used[s] = 1'b0;

      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.func       <= pes_pkg::FUNC_REGISTER;
      req_ch.job_id     <= 16'h0000;
      req_ch.job_period <= 16'h0000;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_fire_on_empty_table();
      test_ties_and_extremes();
      test_random_traffic(RANDOM_ITEMS, 0, 0);
      test_random_traffic(RANDOM_ITEMS, 87, 0);
      test_random_traffic(RANDOM_ITEMS, 0, 87);
      test_random_traffic(RANDOM_ITEMS, 38, 38);
      test_receiver_backpressure();
      test_zero_period();
      test_table_full();

      // quiet tail: catches any stray response after the last expected one
      repeat (END_QUIET_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("periodic_event_scheduler_test OK");
      end else begin
         $display("periodic_event_scheduler_test NOT OK");
      end
      $finish;
   end

endmodule

// ----- periodic_event_scheduler.f -----
src/pes_pkg.sv
src/pes_if.sv
src/pes_cell.sv
src/periodic_event_scheduler.sv
tb/periodic_event_scheduler_test.sv
